[hdl/tcw_pkg.sv]
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  // Field widths fixed by the stream formats
  localparam int KIND_W      = 2;
  localparam int CODE_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int OFFSET_W    = 11;
  localparam int CELL_W      = 16;
  localparam int COLOUR_W    = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input kinds
  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

  // Character codes
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_DEL   = 8'h7F;

  localparam int TAB_STEP = 8;

  localparam logic [COLOUR_W-1:0] FG_RESET   = 4'd2;
  localparam logic [COLOUR_W-1:0] BG_RESET   = 4'd0;
  localparam logic [CELL_W-1:0]   RESET_CELL = 16'h0220;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BACKSPACE,
    OP_TAB,
    OP_CR,
    OP_LF,
    OP_PRINT,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [CODE_W-1:0]   code;
    logic [INDEX_W-1:0]  idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL
  } state_t;

  typedef struct packed {
    logic init_busy;
    logic pop;
    logic load_out;
  } back_status_t;

endpackage

[hdl/tcw_front.sv]
// Input side: accepts stream items and decodes them into queue commands.
`timescale 1ns / 1ps
module tcw_front #(
  parameter int CELL_COUNT = 2000
) (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [tcw_pkg::KIND_W-1:0]      in_tuser,
  input  logic                            init_busy,
  input  logic                            q_full,
  output logic                            q_push,
  output tcw_pkg::cmd_t                   q_cmd
);
  import tcw_pkg::*;

  logic [CODE_W-1:0]  code;
  logic [INDEX_W-1:0] idx;

  assign code = in_tdata[CODE_W-1:0];
  assign idx  = in_tdata[CODE_W +: INDEX_W];

  // no transfers while the buffer clearing pass after reset runs
  assign in_tready = !q_full && !init_busy;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_cmd.code = code;
    q_cmd.idx  = idx;
    q_cmd.op   = OP_NOP;
    case (in_tuser)
      KIND_PUT: begin
        case (code)
          CH_BS:   q_cmd.op = OP_BACKSPACE;
          CH_TAB:  q_cmd.op = OP_TAB;
          CH_CR:   q_cmd.op = OP_CR;
          CH_LF:   q_cmd.op = OP_LF;
          default: begin
            if (code inside {[CH_SPACE:CH_DEL]}) q_cmd.op = OP_PRINT;
          end
        endcase
      end
      KIND_CLEAR: q_cmd.op = OP_CLEAR;
      KIND_READ: begin
        // out-of-range reads return zero data, same as a no-op
        if (32'(idx) < CELL_COUNT) q_cmd.op = OP_READ;
      end
      default: q_cmd.op = OP_NOP;
    endcase
  end

endmodule

[hdl/tcw_cmd_fifo.sv]
// Short command queue between the decode front and the execution back.
`timescale 1ns / 1ps
module tcw_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcw_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tcw_pkg::cmd_t  head_cmd
);
  import tcw_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

[hdl/tcw_back.sv]
// Execution side: cell buffer, cursor, clear and scroll sweeps, result register.
`timescale 1ns / 1ps
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tcw_pkg::COLOUR_W-1:0]  fg_colour,
  input  logic [tcw_pkg::COLOUR_W-1:0]  bg_colour,
  input  logic                          q_valid,
  input  tcw_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tcw_pkg::OFFSET_W-1:0]  out_offset,
  output logic [tcw_pkg::CELL_W-1:0]    out_cell,
  output tcw_pkg::back_status_t         status
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CXW   = $clog2(COLUMNS + TAB_STEP);
  localparam int RXW   = RW + 1;
  localparam int OW    = (AW > OFFSET_W) ? AW : OFFSET_W;

  state_t state_r, state_nxt;

  logic [CLW-1:0] col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [AW-1:0]  sweep_r, sweep_nxt;
  logic           sweep_last;

  logic              out_valid_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [CELL_W-1:0] out_cell_r;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              take, out_free, load_out;
  logic [CELL_W-1:0] load_cell;
  logic [CELL_W-1:0] blank;

  logic [CXW-1:0] colx;
  logic [RXW-1:0] rowx;
  logic [CLW-1:0] mv_col;
  logic [RW-1:0]  mv_row;
  logic           mv_scroll;

  logic [OW-1:0]  cur_lin, off_nxt;
  logic [AW:0]    src_sum;
  logic [AW-1:0]  src_next;

  assign blank      = {bg_colour, fg_colour, CH_SPACE};
  assign out_free   = !out_valid_r || out_tready;
  assign take       = (state_r == ST_IDLE) && q_valid && out_free;
  assign sweep_last = (sweep_r == AW'(CELLS - 1));
  assign cur_lin    = OW'(row_r) * OW'(COLUMNS) + OW'(col_r);
  assign off_nxt    = OW'(row_nxt) * OW'(COLUMNS) + OW'(col_nxt);

  // scroll source runs one row and one cell ahead of the write pointer
  assign src_sum  = {1'b0, sweep_r} + (AW + 1)'(COLUMNS + 1);
  assign src_next = (src_sum < (AW + 1)'(CELLS)) ? src_sum[AW-1:0] : '0;

  // cursor move for a put command, with wrap and scroll detection
  always_comb begin
    colx      = CXW'(col_r);
    rowx      = RXW'(row_r);
    mv_scroll = 1'b0;
    case (q_cmd.op)
      OP_BACKSPACE: if (col_r != '0) colx = CXW'(col_r) - CXW'(1);
      OP_TAB:       colx = (CXW'(col_r) + CXW'(TAB_STEP)) & ~CXW'(TAB_STEP - 1);
      OP_CR:        colx = '0;
      OP_LF: begin
        colx = '0;
        rowx = RXW'(row_r) + RXW'(1);
      end
      OP_PRINT:     colx = CXW'(col_r) + CXW'(1);
      default: ;
    endcase
    if (colx >= CXW'(COLUMNS)) begin
      colx = '0;
      rowx = rowx + RXW'(1);
    end
    if (rowx >= RXW'(ROWS)) begin
      rowx      = RXW'(ROWS - 1);
      colx      = '0;
      mv_scroll = 1'b1;
    end
    mv_col = colx[CLW-1:0];
    mv_row = rowx[RW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: if (sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          case (q_cmd.op)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_READ:  state_nxt = ST_READ;
            default:  if (mv_scroll) state_nxt = ST_SCROLL;
          endcase
        end
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_CLEAR:  if (sweep_last) state_nxt = ST_IDLE;
      ST_SCROLL: if (sweep_last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = blank;
    mem_raddr = src_next;
    sweep_nxt = sweep_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    load_out  = 1'b0;
    load_cell = '0;
    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        sweep_nxt = sweep_last ? '0 : sweep_r + AW'(1);
      end
      ST_IDLE: begin
        q_pop     = take;
        mem_raddr = (q_cmd.op == OP_READ) ? AW'(q_cmd.idx) : AW'(COLUMNS);
        if (take) begin
          case (q_cmd.op)
            OP_CLEAR: begin
              col_nxt = '0;
              row_nxt = '0;
            end
            OP_READ: ;
            default: begin
              col_nxt = mv_col;
              row_nxt = mv_row;
              if (q_cmd.op == OP_PRINT) begin
                mem_we    = 1'b1;
                mem_waddr = cur_lin[AW-1:0];
                mem_wdata = {bg_colour, fg_colour, q_cmd.code};
              end
              if (!mv_scroll) load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load_out  = 1'b1;
        load_cell = rdata_r;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_last ? '0 : sweep_r + AW'(1);
        load_out  = sweep_last;
      end
      ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = (sweep_r < AW'(CELLS - COLUMNS)) ? rdata_r : blank;
        sweep_nxt = sweep_last ? '0 : sweep_r + AW'(1);
        load_out  = sweep_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_offset_r <= off_nxt[OFFSET_W-1:0];
      out_cell_r   <= load_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  assign out_tvalid       = out_valid_r;
  assign out_offset       = out_offset_r;
  assign out_cell         = out_cell_r;
  assign status.init_busy = (state_r == ST_INIT);
  assign status.pop       = q_pop;
  assign status.load_out  = load_out;

endmodule

[hdl/text_console_writer.sv]
// Top level of the text console writer: config registers, front, queue and back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in_     | slave     | in_tvalid/tready   | tdata: char_code, cell_index; tuser: kind
//  out_    | master    | out_tvalid/tready  | tdata: cursor_offset, cell_data
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (colour nibble)
//
// Cursor moves, printable and ignored codes are executed in ST_IDLE of the back end; a read
// goes on through ST_READ (registered buffer read). A clear and a scroll each sweep all
// ROWS*COLUMNS cells, one cell per cycle through the single buffer write port.
// After reset a clearing pass over all ROWS*COLUMNS cells (2000 by default) fills the buffer;
// in_tready stays low during it, config writes are taken. A stalled out_ holds the back
// end, while the front keeps taking items until the command queue is full.
`timescale 1ns / 1ps
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] char_code, [18:8] cell_index, [23:19] zero
  input  logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  logic [tcw_pkg::KIND_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [10:0] cursor_offset, [26:11] cell_data, [31:27] zero
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::COLOUR_W-1:0]      cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  logic [COLOUR_W-1:0] fg_r, bg_r;
  logic                q_push, q_full, q_pop, q_valid;
  cmd_t                push_cmd, head_cmd;
  back_status_t        back_st;
  logic [OFFSET_W-1:0] out_offset;
  logic [CELL_W-1:0]   out_cell;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FG:  fg_r <= cfg_data;
        CFG_BG:  bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .CELL_COUNT (CELLS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_busy (back_st.init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tcw_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fg_colour  (fg_r),
    .bg_colour  (bg_r),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_offset (out_offset),
    .out_cell   (out_cell),
    .status     (back_st)
  );

  assign out_tdata = {{(OUT_TDATA_W - OFFSET_W - CELL_W){1'b0}}, out_cell, out_offset};

  // the clearing pass after reset must not start any command
  a_init_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.init_busy |-> !back_st.pop)
    else $error("command taken during clearing pass");

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.pop |-> q_valid)
    else $error("pop from empty command queue");

  // a new result must never overwrite one still waiting on out_
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.load_out |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the text console writer: screen mirror, stream drivers, checks.
`timescale 1ns / 1ps
module testbench;
  import tcw_pkg::*;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int CLK_HALF     = 6;
  localparam int STALL_LIMIT  = 20000;  // init sweep + scroll + queued sweeps, with margin
  localparam int TAIL_CYCLES  = 2100;   // longer than one scroll sweep
  localparam int REPORT_MAX   = 10;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [CELL_W-1:0]   cell_data;
  } console_result_t;

  // Mirror of the screen buffer and cursor; owns the queue of results still owed.
  class console_mirror;
    bit [CELL_W-1:0]   cells [SCREEN_CELLS];
    int unsigned       col;
    int unsigned       row;
    bit [COLOUR_W-1:0] fg;
    bit [COLOUR_W-1:0] bg;
    console_result_t   owed_results [$];
    int                errors;

    function new();
      fg  = FG_RESET;
      bg  = BG_RESET;
      col = 0;
      row = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = RESET_CELL;
    endfunction

    function bit [CELL_W-1:0] blank();
      return {bg, fg, CH_SPACE};
    endfunction

    function void set_colour(logic [CFG_IDX_W-1:0] index, logic [COLOUR_W-1:0] value);
      if (index == CFG_FG) fg = value;
      else if (index == CFG_BG) bg = value;
    endfunction

    function int unsigned cursor_pos();
      return row * SCREEN_COLS + col;
    endfunction

    function void put_char(logic [CODE_W-1:0] code);
      if (code == CH_BS) begin
        if (col != 0) col--;
      end else if (code == CH_TAB) begin
        col = (col / TAB_STEP + 1) * TAB_STEP;
      end else if (code == CH_CR) begin
        col = 0;
      end else if (code == CH_LF) begin
        col = 0;
        row++;
      end else if (code >= CH_SPACE && code <= CH_DEL) begin
        if (cursor_pos() < SCREEN_CELLS) cells[cursor_pos()] = {bg, fg, code};
        col++;
      end
      if (col >= SCREEN_COLS) begin
        col = 0;
        row++;
      end
      if (row >= SCREEN_ROWS) begin
        for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) cells[i] = cells[i + SCREEN_COLS];
        for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) cells[i] = blank();
        row = SCREEN_ROWS - 1;
        col = 0;
      end
    endfunction

    function void log_command(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                              logic [INDEX_W-1:0] idx);
      console_result_t r;
      r.cell_data = '0;
      case (kind)
        KIND_PUT: put_char(code);
        KIND_CLEAR: begin
          foreach (cells[i]) cells[i] = blank();
          col = 0;
          row = 0;
        end
        KIND_READ: if (idx < SCREEN_CELLS) r.cell_data = cells[idx];
        default: ;
      endcase
      r.offset = OFFSET_W'(cursor_pos());
      owed_results.push_back(r);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void match_readback(logic [OFFSET_W-1:0] offset, logic [CELL_W-1:0] cell_data);
      console_result_t exp_r;
      if (owed_results.size() == 0) begin
        flag($sformatf("unexpected transfer: offset %0d cell %h", offset, cell_data));
        return;
      end
      exp_r = owed_results.pop_front();
      if (offset !== exp_r.offset || cell_data !== exp_r.cell_data)
        flag($sformatf("mismatch: expected offset %0d cell %h, got offset %0d cell %h",
                       exp_r.offset, exp_r.cell_data, offset, cell_data));
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COLOUR_W-1:0]    cfg_data = '0;

  console_mirror mirror;
  int            burst_left = 0;
  int            quiet_cycles = 0;
  int            rx_mode = 0;
  int            rx_left = 0;
  int            rx_tick = 0;

  text_console_writer #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver: switches between always ready, random stalls and a fixed duty pattern.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ((rx_tick % 8) < 3);
    endcase
  end

  // Transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) mirror.set_colour(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        mirror.log_command(in_tuser, in_tdata[CODE_W-1:0], in_tdata[CODE_W +: INDEX_W]);
      if (out_tvalid && out_tready)
        mirror.match_readback(out_tdata[OFFSET_W-1:0], out_tdata[OFFSET_W +: CELL_W]);
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W - CODE_W - INDEX_W){1'b0}}, idx, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] index,
                           input logic [COLOUR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_colours(input logic [COLOUR_W-1:0] fg, input logic [COLOUR_W-1:0] bg);
    drain();
    write_cfg(CFG_FG, fg);
    write_cfg(CFG_BG, bg);
  endtask

  // One random command; lf_pct steers how fast the cursor walks down the screen.
  task automatic send_random(input int lf_pct, input int clear_pct);
    int                 r;
    int unsigned        pos;
    int unsigned        lo;
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  code;
    logic [INDEX_W-1:0] idx;
    kind = KIND_PUT;
    code = CODE_W'($urandom_range(0, 255));
    idx  = INDEX_W'($urandom_range(0, 2047));
    r    = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < lf_pct) begin
      code = CH_LF;
    end else if (r < clear_pct) begin
      kind = KIND_CLEAR;
    end else if (r < 60) begin
      code = CODE_W'($urandom_range(CH_SPACE, CH_DEL));
    end else if (r < 67) begin
      code = CH_TAB;
    end else if (r < 71) begin
      code = CH_BS;
    end else if (r < 74) begin
      code = CH_CR;
    end else if (r < 78) begin
      // any byte, mostly ignored codes
    end else if (r < 80) begin
      kind = KIND_SPARE;
    end else begin
      kind = KIND_READ;
      r    = $urandom_range(0, 7);
      pos  = mirror.cursor_pos();
      lo   = (pos > 40) ? pos - 40 : 0;
      if (r < 4) idx = INDEX_W'($urandom_range(lo, pos));
      else if (r < 7) idx = INDEX_W'($urandom_range(0, SCREEN_CELLS - 1));
      else idx = INDEX_W'($urandom_range(SCREEN_CELLS, 2047));
    end
    send_item(kind, code, idx);
  endtask

  initial begin
    mirror = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, index extremes, every control code, ignored codes
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_READ, 8'hFF, 11'd1999);
    send_item(KIND_READ, 8'h00, 11'd2000);
    send_item(KIND_READ, 8'h00, 11'd2047);
    send_item(KIND_PUT, 8'h41, 11'd0);
    send_item(KIND_PUT, CH_SPACE, 11'd2047);
    send_item(KIND_PUT, CH_DEL, 11'd0);
    send_item(KIND_PUT, 8'h1F, 11'd0);
    send_item(KIND_PUT, 8'h80, 11'd0);
    send_item(KIND_PUT, 8'hFF, 11'd0);
    send_item(KIND_PUT, 8'h00, 11'd0);
    send_item(KIND_PUT, CH_BS, 11'd0);
    send_item(KIND_PUT, CH_BS, 11'd0);
    send_item(KIND_PUT, CH_BS, 11'd0);
    send_item(KIND_PUT, CH_BS, 11'd0);
    send_item(KIND_PUT, CH_TAB, 11'd0);
    send_item(KIND_PUT, CH_TAB, 11'd0);
    send_item(KIND_PUT, CH_CR, 11'd0);
    send_item(KIND_PUT, CH_LF, 11'd0);
    send_item(KIND_READ, 8'h00, 11'd1);
    send_item(KIND_READ, 8'h00, 11'd2);
    send_item(KIND_SPARE, 8'hFF, 11'h7FF);
    send_item(KIND_CLEAR, 8'hFF, 11'h7FF);
    send_item(KIND_READ, 8'h00, 11'd0);
    send_item(KIND_PUT, 8'h7E, 11'd0);

    // Long lines at extreme colours: wraps
    set_colours(4'hF, 4'hF);
    repeat (100) send_random(2, 0);
    // Dense newlines: the cursor sits on the last row and scrolls
    set_colours(4'h0, 4'h0);
    repeat (100) send_random(35, 0);
    set_colours(COLOUR_W'($urandom_range(0, 15)), COLOUR_W'($urandom_range(0, 15)));
    repeat (100) send_random(10, 1);
    set_colours(COLOUR_W'($urandom_range(0, 15)), COLOUR_W'($urandom_range(0, 15)));
    repeat (100) send_random(15, 2);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tcw_pkg.sv
hdl/tcw_front.sv
hdl/tcw_cmd_fifo.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
sim/testbench.sv
